FILE: rtl/core/roulette_wheel_selection_unit_assert.svh
// Assertion macros shared by the roulette wheel selection modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ROULETTE_WHEEL_SELECTION_UNIT_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTION_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RWS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define RWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define RWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rws_pkg.sv
// Package for the roulette wheel selection unit: widths, codes, states and
// the command and status structs between controller and datapath. No dependencies.
package rws_pkg;

    localparam int POP_DEPTH_DEF = 128;
    localparam int KIND_W        = 2;
    localparam int FIT_W         = 16;
    localparam int FRAC_W        = 16;
    localparam int TOTAL_W       = 23;
    localparam int SEL_W         = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_SELECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_WALK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic capture;
        logic mul;
        logic walk;
        logic res_empty;
        logic res_zero;
        logic res_walk;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic slice_zero;
        logic walk_done;
    } t_stat;

endpackage

FILE: rtl/core/rws_if.sv
// Channel interfaces of the roulette wheel selection unit: the input word
// and the result word. Depends on rws_pkg for the field widths.
interface rws_item_if;
    logic                          valid;
    logic                          ready;
    logic [rws_pkg::KIND_W-1:0]    kind;
    logic [rws_pkg::FIT_W-1:0]     fitness_value;
    logic [rws_pkg::FRAC_W-1:0]    random_fraction;

    modport source (output valid, output kind, output fitness_value,
                    output random_fraction, input ready);
    modport sink   (input valid, input kind, input fitness_value,
                    input random_fraction, output ready);
endinterface

interface rws_result_if;
    logic                          valid;
    logic                          ready;
    logic [rws_pkg::SEL_W-1:0]     selected_index;
    logic                          status;

    modport source (output valid, output selected_index, output status, input ready);
    modport sink   (input valid, input selected_index, input status, output ready);
endinterface

FILE: rtl/core/rws_ctrl.sv
// Controller state machine of the roulette wheel selection unit.
// Depends on rws_pkg and the assertion macro header.
`include "roulette_wheel_selection_unit_assert.svh"

module rws_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rws_pkg::KIND_W-1:0] i_kind,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  rws_pkg::t_stat             i_stat,
    output rws_pkg::t_cmd              o_cmd
);

    rws_pkg::t_state r_state;
    rws_pkg::t_state n_state;
    logic            r_out_vld;
    logic            n_out_vld;
    logic            w_accept;
    logic            w_out_free;

    assign o_in_ready  = (r_state == rws_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rws_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rws_pkg::S_IDLE: begin
                if (w_accept && (i_kind == rws_pkg::KIND_SELECT)) begin
                    n_state = i_stat.count_zero ? rws_pkg::S_OUT : rws_pkg::S_MUL;
                end
            end
            rws_pkg::S_MUL: begin
                n_state = rws_pkg::S_WALK;
            end
            rws_pkg::S_WALK: begin
                if (i_stat.slice_zero || i_stat.walk_done) begin
                    n_state = rws_pkg::S_OUT;
                end
            end
            rws_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = rws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rws_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            rws_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        rws_pkg::KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        rws_pkg::KIND_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        rws_pkg::KIND_SELECT: begin
                            o_cmd.capture   = 1'b1;
                            o_cmd.res_empty = i_stat.count_zero;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rws_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            rws_pkg::S_WALK: begin
                if (i_stat.slice_zero) begin
                    o_cmd.res_zero = 1'b1;
                end else begin
                    o_cmd.walk     = 1'b1;
                    o_cmd.res_walk = i_stat.walk_done;
                end
            end
            rws_pkg::S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    `RWS_ASSERT_IMPL(a_busy_no_accept, i_clk, i_rst_n, r_state != rws_pkg::S_IDLE, !o_in_ready, "input taken while a select is in progress")
    `RWS_ASSERT_NEXT(a_mul_to_walk, i_clk, i_rst_n, r_state == rws_pkg::S_MUL, r_state == rws_pkg::S_WALK, "slice product not followed by the walk")
    `RWS_ASSERT_IMPL(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_vld || i_out_ready, "result register overwritten before it was taken")

endmodule

FILE: rtl/core/rws_datapath.sv
// Datapath of the roulette wheel selection unit: fitness table memory,
// count and total, slice multiply, cumulative walk and result registers.
// Depends on rws_pkg and the assertion macro header.
`include "roulette_wheel_selection_unit_assert.svh"

module rws_datapath #(
    parameter int POP_DEPTH = rws_pkg::POP_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rws_pkg::t_cmd               i_cmd,
    output rws_pkg::t_stat              o_stat,
    input  logic [rws_pkg::FIT_W-1:0]   i_fitness_value,
    input  logic [rws_pkg::FRAC_W-1:0]  i_random_fraction,
    output logic [rws_pkg::SEL_W-1:0]   o_selected_index,
    output logic                        o_status
);

    localparam int IDX_W  = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
    localparam int CNT_W  = $clog2(POP_DEPTH + 1);
    localparam int CUM_W  = rws_pkg::FIT_W + IDX_W;
    localparam int CMP_W  = (CUM_W > rws_pkg::TOTAL_W) ? CUM_W : rws_pkg::TOTAL_W;
    localparam int PROD_W = rws_pkg::FRAC_W + rws_pkg::TOTAL_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POP_DEPTH);

    logic [rws_pkg::FIT_W-1:0]   mem [POP_DEPTH];

    logic [CNT_W-1:0]            r_count;
    logic [rws_pkg::TOTAL_W-1:0] r_total;
    logic [rws_pkg::FRAC_W-1:0]  r_frac;
    logic [rws_pkg::TOTAL_W-1:0] r_slice;
    logic [CNT_W-1:0]            r_addr;
    logic                        r_dvld;
    logic [CNT_W-1:0]            r_didx;
    logic [rws_pkg::FIT_W-1:0]   r_rd_data;
    logic [CUM_W-1:0]            r_cum;
    logic [IDX_W-1:0]            r_res_idx;
    logic                        r_res_st;
    logic [rws_pkg::SEL_W-1:0]   r_sel_idx;
    logic                        r_sel_st;

    logic                        w_can_load;
    logic                        w_issue;
    logic [CUM_W-1:0]            w_cum_next;
    logic                        w_hit;
    logic                        w_last;
    logic [PROD_W-1:0]           w_prod;
    logic [IDX_W+rws_pkg::SEL_W-1:0] w_res_wide;

    assign w_can_load = i_cmd.load && (r_count < CNT_FULL);
    assign w_issue    = i_cmd.walk && (r_addr < r_count);
    assign w_cum_next = r_cum + CUM_W'(r_rd_data);
    assign w_hit      = (CMP_W'(w_cum_next) >= CMP_W'(r_slice));
    assign w_last     = (r_didx == (r_count - 1'b1));
    assign w_prod     = PROD_W'(r_frac) * PROD_W'(r_total);
    assign w_res_wide = {{rws_pkg::SEL_W{1'b0}}, r_res_idx};

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.slice_zero = (r_slice == '0);
    assign o_stat.walk_done  = r_dvld && (w_hit || w_last);

    assign o_selected_index = r_sel_idx;
    assign o_status         = r_sel_st;

    always_ff @(posedge i_clk) begin
        if (w_can_load) begin
            mem[r_count[IDX_W-1:0]] <= i_fitness_value;
        end
        if (w_issue) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_dvld  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_total <= '0;
            end else if (w_can_load) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + rws_pkg::TOTAL_W'(i_fitness_value);
            end
            if (i_cmd.mul) begin
                r_dvld <= 1'b0;
            end else begin
                r_dvld <= w_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_frac <= i_random_fraction;
        end
        if (i_cmd.mul) begin
            r_slice <= w_prod[PROD_W-1:rws_pkg::FRAC_W];
            r_addr  <= '0;
            r_cum   <= '0;
        end else begin
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
                r_didx <= r_addr;
            end
            if (i_cmd.walk && r_dvld) begin
                r_cum <= w_cum_next;
            end
        end
        if (i_cmd.res_empty) begin
            r_res_idx <= '0;
            r_res_st  <= 1'b1;
        end else if (i_cmd.res_zero) begin
            r_res_idx <= '0;
            r_res_st  <= 1'b0;
        end else if (i_cmd.res_walk) begin
            r_res_idx <= r_didx[IDX_W-1:0];
            r_res_st  <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_sel_idx <= w_res_wide[rws_pkg::SEL_W-1:0];
            r_sel_st  <= r_res_st;
        end
    end

    `RWS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "member count beyond table depth")
    `RWS_ASSERT_IMPL(a_empty_total, i_clk, i_rst_n, r_count == '0, r_total == '0, "empty population with a nonzero total")
    `RWS_ASSERT_NEXT(a_full_load, i_clk, i_rst_n, i_cmd.load && !i_cmd.clear && (r_count == CNT_FULL), $stable(r_total) && $stable(r_count), "load into a full table changed the state")

endmodule

FILE: rtl/core/roulette_wheel_selection_unit.sv
// Top level of the roulette wheel selection unit: joins controller and datapath.
// Depends on rws_pkg, rws_if, rws_ctrl and rws_datapath.
// Clear and load words are taken while the unit is idle, and a following word
// is accepted in the next cycle. A select word occupies the unit from its
// acceptance to the next acceptance: first the slice multiply, then the walk
// over the fitness table memory, whose single read port delivers one entry per
// cycle, up to the index finally chosen, then the result register. A select on
// an empty population skips the multiply and the walk, and one whose slice is
// zero ends the walk at once. A finished result waits in an output register, and
// clear and load words continue to be accepted while it does.
module roulette_wheel_selection_unit #(
    parameter int POP_DEPTH = rws_pkg::POP_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rws_item_if.sink            i_item,
    rws_result_if.source        o_result
);

    rws_pkg::t_cmd  w_cmd;
    rws_pkg::t_stat w_stat;

    rws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_kind      (i_item.kind),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rws_datapath #(
        .POP_DEPTH (POP_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_fitness_value   (i_item.fitness_value),
        .i_random_fraction (i_item.random_fraction),
        .o_selected_index  (o_result.selected_index),
        .o_status          (o_result.status)
    );

endmodule
